### hw/rtl/slreg_pkg.sv
// Shared constants for the slot registry: port widths, request and status codes, defaults.
package slreg_pkg;

    // Default geometry and tag width
    localparam int SLOTS_PER_ROW_DEF = 16;
    localparam int TAG_BITS_DEF      = 32;

    // Fixed port widths
    localparam int TAG_IN_W = 32;
    localparam int IDX_IN_W = 16;
    localparam int STATUS_W = 2;
    localparam int GIVEN_W  = 4;

    // Request codes
    localparam logic OP_REGISTER   = 1'b0;
    localparam logic OP_UNREGISTER = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

endpackage

### hw/rtl/slreg_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module slreg_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered: rdata takes the addressed word when re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/slot_registry_with_recycle_stack.sv
// Slot registry: tag table and recycle stack in RAM, allocation and release control.
// A taken request sets the busy register; the done register then follows busy.
// A new request is not taken while busy; busy stays high for the cycle in which the
// tag table and stack read data return and the read-check-write completes.
// The receiver cannot stall: done is a one-cycle pulse and the result ports are registered.
// Reset clears the high-water mark and stack depth; tag data read above the mark is never used.
module slot_registry_with_recycle_stack #(
    parameter int SLOTS_PER_ROW = slreg_pkg::SLOTS_PER_ROW_DEF,
    parameter int TAG_BITS      = slreg_pkg::TAG_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [slreg_pkg::TAG_IN_W-1:0] tag_value,
    input  logic [slreg_pkg::IDX_IN_W-1:0] slot_row,
    input  logic [slreg_pkg::IDX_IN_W-1:0] slot_col,
    output logic                           done,
    output logic [slreg_pkg::STATUS_W-1:0] status,
    output logic [slreg_pkg::GIVEN_W-1:0]  given_row,
    output logic [slreg_pkg::GIVEN_W-1:0]  given_col
);

    import slreg_pkg::*;

    localparam int Slots  = SLOTS_PER_ROW * SLOTS_PER_ROW;
    localparam int SlotW  = $clog2(Slots);
    localparam int RowW   = $clog2(SLOTS_PER_ROW);
    localparam int EntW   = 2 * RowW;
    localparam int TagInW = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;

    typedef struct packed {
        logic                op;
        logic [TAG_BITS-1:0] tag;
        logic                in_range;
        logic [RowW-1:0]     row;
        logic [RowW-1:0]     col;
    } req_t;

    // Flat slot index from row and column
    function automatic logic [SlotW-1:0] slot_of(input logic [RowW-1:0] r,
                                                 input logic [RowW-1:0] c);
        slot_of = SlotW'(SlotW'(r) * SlotW'(SLOTS_PER_ROW)) + SlotW'(c);
    endfunction

    // Control state
    logic              busy_reg;
    logic              done_reg;
    logic [SlotW:0]    free_count_reg, free_count_next;
    logic [SlotW:0]    high_water_reg, high_water_next;
    logic [RowW-1:0]   hw_row_reg, hw_row_next;
    logic [RowW-1:0]   hw_col_reg, hw_col_next;

    // Payload
    req_t                req_reg, req_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [GIVEN_W-1:0]  given_row_reg, given_row_next;
    logic [GIVEN_W-1:0]  given_col_reg, given_col_next;

    // Memory ports
    logic                accept;
    logic [SlotW:0]      fc_dec;
    logic [TAG_BITS-1:0] tag_rdata, tag_wdata;
    logic [SlotW-1:0]    tag_waddr;
    logic                tag_we;
    logic [EntW-1:0]     stk_rdata, stk_wdata;
    logic [SlotW-1:0]    stk_waddr;
    logic                stk_we;
    logic [RowW-1:0]     pop_row, pop_col;
    logic [SlotW-1:0]    req_slot;
    logic                unreg_ok;

    // Take a beat when idle; capture the request
    assign accept = start && !busy_reg;
    assign fc_dec = free_count_reg - (SlotW+1)'(1);

    always_comb
    begin
        req_next.op       = req_type;
        req_next.tag      = TAG_BITS'(tag_value[TagInW-1:0]);
        req_next.in_range = (slot_row < IDX_IN_W'(SLOTS_PER_ROW))
                         && (slot_col < IDX_IN_W'(SLOTS_PER_ROW));
        req_next.row      = slot_row[RowW-1:0];
        req_next.col      = slot_col[RowW-1:0];
    end

    // Tag table: read the claimed slot at accept, write back on completion
    slreg_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (Slots)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (accept),
        .raddr (slot_of(req_next.row, req_next.col)),
        .rdata (tag_rdata)
    );

    // Recycle stack: read the top at accept, push on a good release
    slreg_ram #(
        .WIDTH (EntW),
        .DEPTH (Slots)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (accept),
        .raddr (fc_dec[SlotW-1:0]),
        .rdata (stk_rdata)
    );

    assign pop_row  = stk_rdata[EntW-1:RowW];
    assign pop_col  = stk_rdata[RowW-1:0];
    assign req_slot = slot_of(req_reg.row, req_reg.col);
    assign unreg_ok = req_reg.in_range
                   && ({1'b0, req_slot} < high_water_reg)
                   && (tag_rdata != '0)
                   && (tag_rdata == req_reg.tag);

    // Check, allocate or release, and form the result
    always_comb
    begin
        status_next     = ST_REJECT;
        given_row_next  = '0;
        given_col_next  = '0;
        tag_we          = 1'b0;
        tag_waddr       = req_slot;
        tag_wdata       = '0;
        stk_we          = 1'b0;
        stk_waddr       = free_count_reg[SlotW-1:0];
        stk_wdata       = {req_reg.row, req_reg.col};
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        hw_row_next     = hw_row_reg;
        hw_col_next     = hw_col_reg;
        if (busy_reg)
        begin
            if (req_reg.op == OP_REGISTER)
            begin
                if (req_reg.tag == '0)
                begin
                    status_next = ST_REJECT;
                end
                else if (free_count_reg != '0)
                begin
                    // Reuse the most recently freed slot
                    status_next     = ST_DONE;
                    given_row_next  = GIVEN_W'(pop_row);
                    given_col_next  = GIVEN_W'(pop_col);
                    tag_we          = 1'b1;
                    tag_waddr       = slot_of(pop_row, pop_col);
                    tag_wdata       = req_reg.tag;
                    free_count_next = fc_dec;
                end
                else if (high_water_reg < (SlotW+1)'(Slots))
                begin
                    // Take a fresh slot and advance the high-water mark
                    status_next     = ST_DONE;
                    given_row_next  = GIVEN_W'(hw_row_reg);
                    given_col_next  = GIVEN_W'(hw_col_reg);
                    tag_we          = 1'b1;
                    tag_waddr       = high_water_reg[SlotW-1:0];
                    tag_wdata       = req_reg.tag;
                    high_water_next = high_water_reg + (SlotW+1)'(1);
                    if (hw_col_reg == RowW'(SLOTS_PER_ROW - 1))
                    begin
                        hw_col_next = '0;
                        hw_row_next = hw_row_reg + RowW'(1);
                    end
                    else
                    begin
                        hw_col_next = hw_col_reg + RowW'(1);
                    end
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            else if (unreg_ok)
            begin
                // Clear the slot and push it for reuse
                status_next = ST_DONE;
                tag_we      = 1'b1;
                if (free_count_reg < (SlotW+1)'(Slots))
                begin
                    stk_we          = 1'b1;
                    free_count_next = free_count_reg + (SlotW+1)'(1);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            free_count_reg <= '0;
            high_water_reg <= '0;
            hw_row_reg     <= '0;
            hw_col_reg     <= '0;
        end
        else
        begin
            busy_reg       <= accept;
            done_reg       <= busy_reg;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            hw_row_reg     <= hw_row_next;
            hw_col_reg     <= hw_col_next;
        end
    end

    // Hold the request and the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
        if (busy_reg)
        begin
            status_reg    <= status_next;
            given_row_reg <= given_row_next;
            given_col_reg <= given_col_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign given_row = given_row_reg;
    assign given_col = given_col_reg;

    // Every request completes in the cycle after busy, with busy low, and produces one beat
    a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> (done_reg && !busy_reg))
        else $error("request did not complete in one cycle");

    // Freed slots are a subset of allocated slots
    a_stack_within_hw: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= high_water_reg)
        else $error("recycle stack deeper than high-water mark");

    // Row and column counters track the high-water mark
    a_hw_split: assert property (@(posedge clk) disable iff (!rst_n)
        (high_water_reg < (SlotW+1)'(Slots))
        |-> (slot_of(hw_row_reg, hw_col_reg) == high_water_reg[SlotW-1:0]))
        else $error("high-water row and column out of step");

    // Full is reported only with an empty stack and an exhausted table
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_FULL))
        |-> ((free_count_reg == '0) && (high_water_reg == (SlotW+1)'(Slots))))
        else $error("full reported with slots available");

endmodule
